### rtl/iq_downconverter_eighth_rate_top_macros.svh
// assertion helpers, sampled on clk_i and held off while rst_ni is low
`ifndef IQ_DOWNCONVERTER_EIGHTH_RATE_TOP_MACROS_SVH
`define IQ_DOWNCONVERTER_EIGHTH_RATE_TOP_MACROS_SVH

// property that must hold at every edge
`define IQDC8_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition now implies condition in the next cycle
`define IQDC8_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/iqdc8_pkg.sv
package iqdc8_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CNT_W    = 12;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned WGT_W    = 17;
  localparam int unsigned PROD_W   = SAMPLE_W + 1 + WGT_W;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned NUM_SUMS = 4;

  localparam logic [CNT_W-1:0]  SPV_RESET      = 12'd96;
  localparam logic [CNT_W:0]    PAIRS_PER_GRP  = 13'd8;
  localparam logic [SLOT_W-1:0] LAST_SLOT      = 3'd7;

  localparam logic signed [WGT_W-1:0] W_FULL = 17'sd32768;
  localparam logic signed [WGT_W-1:0] W_DIAG = 17'sd23170;
  localparam logic signed [WGT_W-1:0] W_ZERO = 17'sd0;

  // sum order: ch0 re, ch0 im, ch1 re, ch1 im
  typedef struct packed {
    logic                          valid;
    logic [NUM_SUMS-1:0][SUM_W-1:0] sums;
  } grp_t;

  function automatic logic signed [WGT_W-1:0] cos_w(input logic [SLOT_W-1:0] k);
    logic signed [WGT_W-1:0] w;
    unique case (k)
      3'd0:    w = W_FULL;
      3'd1:    w = W_DIAG;
      3'd2:    w = W_ZERO;
      3'd3:    w = -W_DIAG;
      3'd4:    w = -W_FULL;
      3'd5:    w = -W_DIAG;
      3'd6:    w = W_ZERO;
      default: w = W_DIAG;
    endcase
    return w;
  endfunction

  function automatic logic signed [WGT_W-1:0] sin_w(input logic [SLOT_W-1:0] k);
    logic signed [WGT_W-1:0] w;
    unique case (k)
      3'd0:    w = W_ZERO;
      3'd1:    w = W_DIAG;
      3'd2:    w = W_FULL;
      3'd3:    w = W_DIAG;
      3'd4:    w = W_ZERO;
      3'd5:    w = -W_DIAG;
      3'd6:    w = -W_FULL;
      default: w = -W_DIAG;
    endcase
    return w;
  endfunction

  // divide by 128, rounding toward zero
  function automatic logic signed [SUM_W-1:0] div128(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] bias;
    bias = x[SUM_W-1] ? 32'sd127 : 32'sd0;
    return (x + bias) >>> 7;
  endfunction

  // divide by 256, rounding toward zero, keep the output width
  function automatic logic [OUT_W-1:0] div256(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] bias;
    logic signed [SUM_W-1:0] q;
    bias = x[SUM_W-1] ? 32'sd255 : 32'sd0;
    q    = (x + bias) >>> 8;
    return q[OUT_W-1:0];
  endfunction

endpackage

### rtl/iq_downconverter_eighth_rate_top.sv
// channel  | dir | handshake                       | payload
// s_axis   | in  | s_axis_tvalid_i/s_axis_tready_o | sample pair (24 bits)
// m_axis   | out | m_axis_tvalid_o/m_axis_tready_i | four iq results (96 bits)
// cfg      | in  | cfg_valid_i/cfg_ready_o         | samples_per_value (12 bits)
//
// one pair per cycle unless stalled; input, multiply, group sum, running sum and
// output registers; a result per samples_per_value pairs, in whole groups of eight
// reset clears slot, pair count, group and running sums; samples_per_value is 96
// a held result stalls intake only when the next result is already one stage
// behind it; otherwise pairs keep flowing while the result waits
module iq_downconverter_eighth_rate_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // sample_a [11:0], sample_b [23:12]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,  // ch0_re [23:0], ch0_im [47:24],
                                       // ch1_re [71:48], ch1_im [95:72]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [11:0] cfg_data_i
);

  `include "iq_downconverter_eighth_rate_top_macros.svh"

  localparam int unsigned SW = iqdc8_pkg::SUM_W;
  localparam int unsigned OW = iqdc8_pkg::OUT_W;
  localparam int unsigned CW = iqdc8_pkg::CNT_W;

  logic                   adv;
  iqdc8_pkg::grp_t        grp;

  logic [CW-1:0]          spv_q;
  logic [CW-1:0]          cnt_q;
  logic [CW:0]            cnt_next;
  logic                   dump;

  logic signed [SW-1:0]   run_q  [iqdc8_pkg::NUM_SUMS];
  logic signed [SW-1:0]   run_d  [iqdc8_pkg::NUM_SUMS];
  logic signed [SW-1:0]   dmp_q  [iqdc8_pkg::NUM_SUMS];
  logic                   dv_q;

  logic                   out_valid_q;
  logic [95:0]            out_data_q;

  // freeze the pipe only when a new result would land on a stalled one
  assign adv             = !(dv_q && out_valid_q && !m_axis_tready_i);
  assign s_axis_tready_o = adv;
  assign cfg_ready_o     = 1'b1;

  iqdc8_mixer u_mixer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (s_axis_tvalid_i),
    .sample_a_i (s_axis_tdata_i[11:0]),
    .sample_b_i (s_axis_tdata_i[23:12]),
    .grp_o      (grp)
  );

  always_comb begin
    cnt_next = {1'b0, cnt_q} + iqdc8_pkg::PAIRS_PER_GRP;
    dump     = cnt_next >= {1'b0, spv_q};
    for (int i = 0; i < iqdc8_pkg::NUM_SUMS; i++) begin
      run_d[i] = run_q[i] + iqdc8_pkg::div128($signed(grp.sums[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spv_q <= iqdc8_pkg::SPV_RESET;
    end else if (cfg_valid_i) begin
      spv_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      dv_q  <= 1'b0;
      for (int i = 0; i < iqdc8_pkg::NUM_SUMS; i++) begin
        run_q[i] <= '0;
      end
    end else if (adv) begin
      dv_q <= grp.valid && dump;
      if (grp.valid) begin
        cnt_q <= dump ? '0 : cnt_next[CW-1:0];
        for (int i = 0; i < iqdc8_pkg::NUM_SUMS; i++) begin
          run_q[i] <= dump ? '0 : run_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && grp.valid && dump) begin
      for (int i = 0; i < iqdc8_pkg::NUM_SUMS; i++) begin
        dmp_q[i] <= run_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (adv && dv_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && dv_q) begin
      for (int i = 0; i < iqdc8_pkg::NUM_SUMS; i++) begin
        out_data_q[i*OW +: OW] <= iqdc8_pkg::div256(dmp_q[i]);
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // counts advance in whole groups
  `IQDC8_ASSERT(a_cnt_group_aligned, cnt_q[2:0] == 3'd0, "pair count not group aligned")
  // dumps come at least a group apart
  `IQDC8_ASSERT_NEXT(a_dump_spacing, dv_q && adv, !dv_q, "back to back dumps")
  // a result only appears out of the dump stage
  `IQDC8_ASSERT(a_out_from_dump, $rose(m_axis_tvalid_o) |-> $past(dv_q),
                "result without a dump")

endmodule

### rtl/iqdc8_mixer.sv
module iqdc8_mixer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [iqdc8_pkg::SAMPLE_W-1:0]    sample_a_i,
  input  logic [iqdc8_pkg::SAMPLE_W-1:0]    sample_b_i,
  output iqdc8_pkg::grp_t                   grp_o
);

  localparam int unsigned PW = iqdc8_pkg::PROD_W;
  localparam int unsigned SW = iqdc8_pkg::SUM_W;

  // input register
  logic                               v1_q;
  logic [iqdc8_pkg::SLOT_W-1:0]       slot_q, slot1_q;
  logic [iqdc8_pkg::SAMPLE_W-1:0]     a1_q, b1_q;

  // product register
  logic                               v2_q;
  logic [iqdc8_pkg::SLOT_W-1:0]       slot2_q;
  logic signed [PW-1:0]               p_q [iqdc8_pkg::NUM_SUMS];
  logic signed [PW-1:0]               p_d [iqdc8_pkg::NUM_SUMS];

  // group sums
  logic signed [SW-1:0]               gs_q [iqdc8_pkg::NUM_SUMS];
  logic signed [SW-1:0]               gs_d [iqdc8_pkg::NUM_SUMS];
  logic                               grp_valid_q;
  logic [iqdc8_pkg::NUM_SUMS-1:0][SW-1:0] grp_sums_q;

  logic signed [iqdc8_pkg::WGT_W-1:0] wc, ws;
  logic signed [iqdc8_pkg::SAMPLE_W:0] sa, sb;

  always_comb begin
    wc     = iqdc8_pkg::cos_w(slot1_q);
    ws     = iqdc8_pkg::sin_w(slot1_q);
    sa     = $signed({1'b0, a1_q});
    sb     = $signed({1'b0, b1_q});
    p_d[0] = sa * wc;
    p_d[1] = sa * ws;
    p_d[2] = sb * wc;
    p_d[3] = sb * ws;
  end

  always_comb begin
    for (int i = 0; i < iqdc8_pkg::NUM_SUMS; i++) begin
      gs_d[i] = gs_q[i] + $signed({{(SW-PW){p_q[i][PW-1]}}, p_q[i]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      slot_q <= '0;
    end else if (en_i) begin
      v1_q <= valid_i;
      if (valid_i) begin
        slot_q <= slot_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      a1_q    <= sample_a_i;
      b1_q    <= sample_b_i;
      slot1_q <= slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && v1_q) begin
      slot2_q <= slot1_q;
      for (int i = 0; i < iqdc8_pkg::NUM_SUMS; i++) begin
        p_q[i] <= p_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      for (int i = 0; i < iqdc8_pkg::NUM_SUMS; i++) begin
        gs_q[i] <= '0;
      end
    end else if (en_i) begin
      grp_valid_q <= v2_q && (slot2_q == iqdc8_pkg::LAST_SLOT);
      if (v2_q) begin
        for (int i = 0; i < iqdc8_pkg::NUM_SUMS; i++) begin
          gs_q[i] <= (slot2_q == iqdc8_pkg::LAST_SLOT) ? '0 : gs_d[i];
        end
      end
    end
  end

  // closing sums of a group, handed on with the last pair
  always_ff @(posedge clk_i) begin
    if (en_i && v2_q && (slot2_q == iqdc8_pkg::LAST_SLOT)) begin
      for (int i = 0; i < iqdc8_pkg::NUM_SUMS; i++) begin
        grp_sums_q[i] <= gs_d[i];
      end
    end
  end

  assign grp_o = {grp_valid_q, grp_sums_q};

endmodule
